// ===== src/fds_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, widths and constants for the dielectric scatter sampler.
// Used by fds_sqrt and fresnel_dielectric_scatter.
package fds_pkg;

	localparam int DIR_W     = 18;
	localparam int RAND_W    = 16;
	localparam int MASK_W    = 3;
	localparam int CFG_W     = 19;
	localparam int CFG_IDX_W = 2;
	localparam int PDF_W     = 17;
	localparam int WEIGHT_W  = 24;
	localparam int KIND_W    = 2;

	// square root: 33-bit radicand, 17-bit root
	localparam int RAD_W  = 33;
	localparam int ROOT_W = 17;

	// Fresnel ratio divide: 38-bit operands, 17 quotient bits
	localparam int RATIO_DW = 38;
	localparam int RATIO_QW = 17;

	// weight divide: 17-bit divisor, 24 quotient bits
	localparam int WDIV_DW = 17;
	localparam int WDIV_QW = 24;

	localparam logic [CFG_W-1:0] ETA_ENTER_RST = 19'd65536;
	localparam logic [CFG_W-1:0] ETA_LEAVE_RST = 19'd65536;
	localparam logic [CFG_W-1:0] INDEX_INC_RST = 19'd65536;
	localparam logic [CFG_W-1:0] INDEX_TRN_RST = 19'd98304;

	localparam logic [16:0] Q_ONE     = 17'd65536;
	localparam logic [16:0] Q_QUARTER = 17'd16384;
	localparam logic [WEIGHT_W-1:0] WEIGHT_MAX = 24'hFFFFFF;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_ETA_ENTER = 2'd0,
		CFG_ETA_LEAVE = 2'd1,
		CFG_INDEX_INC = 2'd2,
		CFG_INDEX_TRN = 2'd3
	} cfg_reg_t;

	typedef enum logic [KIND_W-1:0] {
		KIND_NONE  = 2'd0,
		KIND_REFL  = 2'd1,
		KIND_TRANS = 2'd2
	} path_kind_t;

	// carried alongside the square root
	typedef struct packed {
		logic                    refl_ok;
		logic                    trans_ok;
		logic                    entering;
		logic [RAND_W-1:0]       w;
		logic signed [DIR_W-1:0] rx;
		logic signed [DIR_W-1:0] ry;
		logic signed [DIR_W-1:0] rz;
		logic signed [DIR_W-1:0] tx;
		logic signed [DIR_W-1:0] ty;
		logic [DIR_W-1:0]        ci;
	} fds_front_t;

	// carried alongside the ratio divide
	typedef struct packed {
		fds_front_t        f;
		logic [ROOT_W-1:0] cost;
		logic              dz;
	} fds_mid_t;

	// carried alongside the weight divide
	typedef struct packed {
		logic signed [DIR_W-1:0] nx;
		logic signed [DIR_W-1:0] ny;
		logic signed [DIR_W-1:0] nz;
		logic [PDF_W-1:0]        pdf;
		path_kind_t              kind;
		logic                    zero_num;
		logic                    ovf;
	} fds_tail_t;

	function automatic logic signed [DIR_W-1:0] clamp_unit(input logic signed [DIR_W:0] v);
		logic signed [DIR_W-1:0] r;
		if (v > 19'sd65536)
			r = 18'sd65536;
		else if (v < -19'sd65536)
			r = -18'sd65536;
		else
			r = v[DIR_W-1:0];
		return r;
	endfunction

endpackage

// ===== src/fresnel_dielectric_scatter.sv =====
`timescale 1ns / 1ps
// Smooth dielectric scatter sampler: Fresnel reflectance, lobe pick, pdf and weight.
// Depends on fds_pkg, fds_sqrt and fds_div.
//
// Usage
//   Command side: drive dir_x/y/z, rand_w and allow_mask with start high; the beat
//   is taken at any rising edge where start is high and busy is low. busy never
//   rises, so a new beat may be issued every cycle.
//   Result side: done is high for exactly one cycle with new_x/y/z, pdf_value,
//   weight and path_kind valid; results leave in the order the beats came in.
//   There is no back-pressure, the receiver must take every result.
//   From the accepting edge to the edge that ends the done cycle a beat passes
//   3 front stages, 17 square root stages, 2 product stages, 17 ratio divide
//   stages, 3 mix stages, 24 weight divide stages and the output register.
//   Throughput is one beat per clock; every stage is a plain shift with a valid bit.
//   Configuration: cfg_we with cfg_idx selects eta_entering, eta_leaving,
//   index_incident or index_transmit; write only when no beat is in flight.
//   Reset clears all valid bits and loads the register defaults (1.0, 1.0, 1.0, 1.5).
module fresnel_dielectric_scatter (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic signed [fds_pkg::DIR_W-1:0] dir_x,
	input  logic signed [fds_pkg::DIR_W-1:0] dir_y,
	input  logic signed [fds_pkg::DIR_W-1:0] dir_z,
	input  logic [fds_pkg::RAND_W-1:0]    rand_w,
	input  logic [fds_pkg::MASK_W-1:0]    allow_mask,
	input  logic                          cfg_we,
	input  logic [fds_pkg::CFG_IDX_W-1:0] cfg_idx,
	input  logic [fds_pkg::CFG_W-1:0]     cfg_wdata,
	output logic                          done,
	output logic signed [fds_pkg::DIR_W-1:0] new_x,
	output logic signed [fds_pkg::DIR_W-1:0] new_y,
	output logic signed [fds_pkg::DIR_W-1:0] new_z,
	output logic [fds_pkg::PDF_W-1:0]     pdf_value,
	output logic [fds_pkg::WEIGHT_W-1:0]  weight,
	output logic [fds_pkg::KIND_W-1:0]    path_kind
);
	import fds_pkg::*;

	localparam int LATENCY = 3 + ROOT_W + 2 + RATIO_QW + 3 + WDIV_QW + 1;

	// configuration registers
	logic [CFG_W-1:0] eta_enter_q, eta_leave_q, index_inc_q, index_trn_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			eta_enter_q <= ETA_ENTER_RST;
			eta_leave_q <= ETA_LEAVE_RST;
			index_inc_q <= INDEX_INC_RST;
			index_trn_q <= INDEX_TRN_RST;
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_idx))
				CFG_ETA_ENTER: eta_enter_q <= cfg_wdata;
				CFG_ETA_LEAVE: eta_leave_q <= cfg_wdata;
				CFG_INDEX_INC: index_inc_q <= cfg_wdata;
				CFG_INDEX_TRN: index_trn_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	assign busy = 1'b0;

	logic accept;
	assign accept = start & ~busy;

	// ---------------- stage 1: squares and eta products
	logic [CFG_W-1:0]        e_sel;
	logic [DIR_W-1:0]        ax, ay;
	logic signed [2*DIR_W-1:0] cc_full;

	assign e_sel   = (dir_z > 18'sd0) ? eta_enter_q : eta_leave_q;
	assign ax      = dir_x[DIR_W-1] ? DIR_W'(-dir_x) : DIR_W'(dir_x);
	assign ay      = dir_y[DIR_W-1] ? DIR_W'(-dir_y) : DIR_W'(dir_y);
	assign cc_full = (2*DIR_W)'(dir_z * dir_z);

	logic                    v_s1;
	logic [34:0]             cc_s1;
	logic [2*CFG_W-1:0]      ee_s1;
	logic [CFG_W+DIR_W-1:0]  ex_s1, ey_s1;
	logic signed [DIR_W-1:0] x_s1, y_s1, c_s1;
	logic [RAND_W-1:0]       w_s1;
	logic                    refl_ok_s1, trans_ok_s1, ent_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s1 <= 1'b0;
		else
			v_s1 <= accept;
	end

	always_ff @(posedge clk) begin
		cc_s1       <= cc_full[34:0];
		ee_s1       <= (2*CFG_W)'(e_sel * e_sel);
		ex_s1       <= (CFG_W+DIR_W)'(e_sel * ax);
		ey_s1       <= (CFG_W+DIR_W)'(e_sel * ay);
		x_s1        <= dir_x;
		y_s1        <= dir_y;
		c_s1        <= dir_z;
		w_s1        <= rand_w;
		refl_ok_s1  <= allow_mask[0] & allow_mask[2];
		trans_ok_s1 <= allow_mask[1] & allow_mask[2];
		ent_s1      <= dir_z > 18'sd0;
	end

	// ---------------- stage 2: sin^2, eta^2 * sin^2, candidate directions
	logic [32:0]  s2_diff;
	logic [16:0]  s2;
	logic [54:0]  kp;
	logic [20:0]  tpx, tpy;
	logic [16:0]  tmx, tmy;
	fds_front_t   front_d2;

	assign s2_diff = 33'h1_0000_0000 - {1'b0, cc_s1[31:0]};
	assign s2      = (|cc_s1[34:32]) ? 17'd0 : s2_diff[32:16];
	assign kp      = 55'(ee_s1 * s2);
	assign tpx     = ex_s1[36:16];
	assign tpy     = ey_s1[36:16];
	assign tmx     = (tpx > 21'd65536) ? Q_ONE : tpx[16:0];
	assign tmy     = (tpy > 21'd65536) ? Q_ONE : tpy[16:0];

	always_comb begin
		front_d2.refl_ok  = refl_ok_s1;
		front_d2.trans_ok = trans_ok_s1;
		front_d2.entering = ent_s1;
		front_d2.w        = w_s1;
		front_d2.rx       = clamp_unit(-$signed({x_s1[DIR_W-1], x_s1}));
		front_d2.ry       = clamp_unit(-$signed({y_s1[DIR_W-1], y_s1}));
		front_d2.rz       = clamp_unit($signed({c_s1[DIR_W-1], c_s1}));
		front_d2.tx       = x_s1[DIR_W-1] ? $signed({1'b0, tmx}) : -$signed({1'b0, tmx});
		front_d2.ty       = y_s1[DIR_W-1] ? $signed({1'b0, tmy}) : -$signed({1'b0, tmy});
		front_d2.ci       = c_s1[DIR_W-1] ? DIR_W'(-c_s1) : DIR_W'(c_s1);
	end

	logic        v_s2;
	logic [38:0] k_s2;
	fds_front_t  front_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s2 <= 1'b0;
		else
			v_s2 <= v_s1;
	end

	always_ff @(posedge clk) begin
		k_s2     <= kp[54:16];
		front_s2 <= front_d2;
	end

	// ---------------- stage 3: cos^2 of the refracted ray
	logic [RAD_W-1:0] t_d3;
	assign t_d3 = (|k_s2[38:32]) ? '0 : 33'h1_0000_0000 - {1'b0, k_s2[31:0]};

	logic             v_s3;
	logic [RAD_W-1:0] t_s3;
	fds_front_t       front_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s3 <= 1'b0;
		else
			v_s3 <= v_s2;
	end

	always_ff @(posedge clk) begin
		t_s3     <= t_d3;
		front_s3 <= front_s2;
	end

	// ---------------- square root
	logic              sq_v;
	logic [ROOT_W-1:0] sq_root;
	fds_front_t        sq_front;

	fds_sqrt #(
		.SIDE_W($bits(fds_front_t))
	) u_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (v_s3),
		.radicand (t_s3),
		.in_side  (front_s3),
		.out_valid(sq_v),
		.root     (sq_root),
		.out_side (sq_front)
	);

	// ---------------- stage 4: Fresnel products
	logic              v_s4;
	logic [36:0]       a1_s4, b1_s4, a2_s4, b2_s4;
	logic [ROOT_W-1:0] cost_s4;
	fds_front_t        front_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s4 <= 1'b0;
		else
			v_s4 <= sq_v;
	end

	always_ff @(posedge clk) begin
		a1_s4    <= 37'(index_trn_q * sq_front.ci);
		b1_s4    <= 37'(index_inc_q * sq_root);
		a2_s4    <= 37'(index_inc_q * sq_front.ci);
		b2_s4    <= 37'(index_trn_q * sq_root);
		cost_s4  <= sq_root;
		front_s4 <= sq_front;
	end

	// ---------------- stage 5: ratio numerators and denominators
	logic [36:0] num1_d5, num2_d5;
	assign num1_d5 = (a1_s4 > b1_s4) ? a1_s4 - b1_s4 : b1_s4 - a1_s4;
	assign num2_d5 = (a2_s4 > b2_s4) ? a2_s4 - b2_s4 : b2_s4 - a2_s4;

	logic                v_s5;
	logic [36:0]         num1_s5, num2_s5;
	logic [RATIO_DW-1:0] den1_s5, den2_s5;
	fds_mid_t            mid_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s5 <= 1'b0;
		else
			v_s5 <= v_s4;
	end

	always_ff @(posedge clk) begin
		num1_s5     <= num1_d5;
		num2_s5     <= num2_d5;
		den1_s5     <= {1'b0, a1_s4} + {1'b0, b1_s4};
		den2_s5     <= {1'b0, a2_s4} + {1'b0, b2_s4};
		mid_s5.f    <= front_s4;
		mid_s5.cost <= cost_s4;
		mid_s5.dz   <= (a1_s4 == '0) && (b1_s4 == '0);
	end

	// ---------------- ratio divides: q = (num << 16) / den
	// num <= den, so num/2 < den is a valid starting remainder
	logic [RATIO_DW-1:0] r0_1, r0_2;
	logic [RATIO_QW-1:0] feed_1, feed_2;
	logic                dz2_d5;

	assign r0_1   = RATIO_DW'(num1_s5[36:1]);
	assign r0_2   = RATIO_DW'(num2_s5[36:1]);
	assign feed_1 = {num1_s5[0], 16'd0};
	assign feed_2 = {num2_s5[0], 16'd0};
	assign dz2_d5 = den2_s5 == '0;

	logic                d1_v, d2_v;
	logic [RATIO_QW-1:0] q1, q2;
	fds_mid_t            d1_mid;
	logic                d2_dz;

	fds_div #(
		.DW    (RATIO_DW),
		.QW    (RATIO_QW),
		.SIDE_W($bits(fds_mid_t))
	) u_ratio1 (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (v_s5),
		.rem_init (r0_1),
		.divisor  (den1_s5),
		.feed     (feed_1),
		.in_side  (mid_s5),
		.out_valid(d1_v),
		.quot     (q1),
		.out_side (d1_mid)
	);

	fds_div #(
		.DW    (RATIO_DW),
		.QW    (RATIO_QW),
		.SIDE_W(1)
	) u_ratio2 (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (v_s5),
		.rem_init (r0_2),
		.divisor  (den2_s5),
		.feed     (feed_2),
		.in_side  (dz2_d5),
		.out_valid(d2_v),
		.quot     (q2),
		.out_side (d2_dz)
	);

	// ---------------- stage 6: squared ratios
	logic [2*RATIO_QW-1:0] qq1, qq2;
	assign qq1 = (2*RATIO_QW)'(q1 * q1);
	assign qq2 = (2*RATIO_QW)'(q2 * q2);

	logic        v_s6;
	logic [16:0] sq1_s6, sq2_s6;
	fds_mid_t    mid_s6;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s6 <= 1'b0;
		else
			v_s6 <= d1_v & d2_v;
	end

	always_ff @(posedge clk) begin
		sq1_s6 <= d1_mid.dz ? Q_ONE : qq1[32:16];
		sq2_s6 <= d2_dz ? Q_ONE : qq2[32:16];
		mid_s6 <= d1_mid;
	end

	// ---------------- stage 7: reflectance and reflection probability
	logic [17:0] rsum;
	logic [16:0] refl_d7;
	assign rsum    = {1'b0, sq1_s6} + {1'b0, sq2_s6};
	assign refl_d7 = (mid_s6.cost == '0) ? Q_ONE : rsum[17:1];

	logic        v_s7;
	logic [16:0] refl_s7, prob_s7;
	fds_mid_t    mid_s7;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s7 <= 1'b0;
		else
			v_s7 <= v_s6;
	end

	always_ff @(posedge clk) begin
		refl_s7 <= refl_d7;
		prob_s7 <= {1'b0, refl_d7[16:1]} + Q_QUARTER;
		mid_s7  <= mid_s6;
	end

	// ---------------- stage 8: lobe pick, direction, pdf, weight operands
	logic                    both, take_refl;
	logic signed [DIR_W-1:0] nz_t;
	logic [16:0]             wnum_d8, den_d8;
	fds_tail_t               tail_d8;

	always_comb begin
		both      = mid_s7.f.refl_ok & mid_s7.f.trans_ok;
		take_refl = (both && ({1'b0, mid_s7.f.w} <= prob_s7)) || (mid_s7.f.refl_ok && !both);
		nz_t      = mid_s7.f.entering ? -$signed({1'b0, mid_s7.cost}) :
		                                 $signed({1'b0, mid_s7.cost});
		tail_d8.nx  = take_refl ? mid_s7.f.rx : mid_s7.f.tx;
		tail_d8.ny  = take_refl ? mid_s7.f.ry : mid_s7.f.ty;
		tail_d8.nz  = take_refl ? mid_s7.f.rz : nz_t;
		tail_d8.pdf = !both ? Q_ONE : (take_refl ? prob_s7 : Q_ONE - prob_s7);
		if (!mid_s7.f.refl_ok && !mid_s7.f.trans_ok)
			tail_d8.kind = KIND_NONE;
		else if (take_refl)
			tail_d8.kind = KIND_REFL;
		else
			tail_d8.kind = KIND_TRANS;
		wnum_d8 = take_refl ? refl_s7 : Q_ONE - refl_s7;
		den_d8  = tail_d8.nz[DIR_W-1] ? 17'(-tail_d8.nz) : tail_d8.nz[16:0];
		tail_d8.zero_num = wnum_d8 == '0;
		// quotient reaches 2^24 exactly when num >= den * 2^8 (also covers den = 0)
		tail_d8.ovf = {8'd0, wnum_d8} >= {den_d8, 8'd0};
	end

	logic               v_s8;
	logic [16:0]        wnum_s8;
	logic [WDIV_DW-1:0] den_s8;
	fds_tail_t          tail_s8;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s8 <= 1'b0;
		else
			v_s8 <= v_s7;
	end

	always_ff @(posedge clk) begin
		wnum_s8 <= wnum_d8;
		den_s8  <= den_d8;
		tail_s8 <= tail_d8;
	end

	// ---------------- weight divide: (num << 16) / |new_z|, 24 bits
	logic               wd_v;
	logic [WDIV_QW-1:0] wq;
	fds_tail_t          wd_tail;

	fds_div #(
		.DW    (WDIV_DW),
		.QW    (WDIV_QW),
		.SIDE_W($bits(fds_tail_t))
	) u_weight (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (v_s8),
		.rem_init (WDIV_DW'(wnum_s8[16:8])),
		.divisor  (den_s8),
		.feed     ({wnum_s8[7:0], 16'd0}),
		.in_side  (tail_s8),
		.out_valid(wd_v),
		.quot     (wq),
		.out_side (wd_tail)
	);

	// ---------------- output register
	logic                    done_q;
	logic signed [DIR_W-1:0] new_x_q, new_y_q, new_z_q;
	logic [PDF_W-1:0]        pdf_q;
	logic [WEIGHT_W-1:0]     weight_q;
	path_kind_t              kind_q;
	logic                    none;

	assign none = wd_tail.kind == KIND_NONE;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			done_q <= 1'b0;
		else
			done_q <= wd_v;
	end

	always_ff @(posedge clk) begin
		new_x_q <= none ? '0 : wd_tail.nx;
		new_y_q <= none ? '0 : wd_tail.ny;
		new_z_q <= none ? '0 : wd_tail.nz;
		pdf_q   <= none ? '0 : wd_tail.pdf;
		kind_q  <= wd_tail.kind;
		if (none || wd_tail.zero_num)
			weight_q <= '0;
		else if (wd_tail.ovf)
			weight_q <= WEIGHT_MAX;
		else
			weight_q <= wq;
	end

	assign done      = done_q;
	assign new_x     = new_x_q;
	assign new_y     = new_y_q;
	assign new_z     = new_z_q;
	assign pdf_value = pdf_q;
	assign weight    = weight_q;
	assign path_kind = kind_q;

	// ---------------- checks
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		accept |-> ##LATENCY done)
		else $error("result strobe missing after accepted beat");

	a_pdf_live: assert property (@(posedge clk) disable iff (!arst_n)
		(done && path_kind != KIND_NONE) |-> pdf_value != '0)
		else $error("sampled lobe with zero pdf");

	a_none_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && path_kind == KIND_NONE) |-> (weight == '0 && new_z == '0 && pdf_value == '0))
		else $error("empty sample carries data");

endmodule

// ===== src/fds_sqrt.sv =====
`timescale 1ns / 1ps
// Pipelined integer square root, one root bit per stage (restoring form).
// Depends on fds_pkg for the radicand and root widths.
module fds_sqrt #(
	parameter int SIDE_W = 1
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	input  logic [fds_pkg::RAD_W-1:0]  radicand,
	input  logic [SIDE_W-1:0]          in_side,
	output logic                       out_valid,
	output logic [fds_pkg::ROOT_W-1:0] root,
	output logic [SIDE_W-1:0]          out_side
);
	import fds_pkg::*;

	localparam int PAD_W = 2 * ROOT_W;
	localparam int REM_W = ROOT_W + 2;

	logic [ROOT_W-1:0] v_s;
	logic [PAD_W-1:0]  rad_s  [ROOT_W];
	logic [REM_W-1:0]  rem_s  [ROOT_W];
	logic [ROOT_W-1:0] root_s [ROOT_W];
	logic [SIDE_W-1:0] side_s [ROOT_W];

	logic [PAD_W-1:0]  rad_i  [ROOT_W];
	logic [REM_W-1:0]  rem_i  [ROOT_W];
	logic [ROOT_W-1:0] root_i [ROOT_W];
	logic [SIDE_W-1:0] side_i [ROOT_W];
	logic [REM_W+1:0]  sh     [ROOT_W];
	logic [REM_W+1:0]  trial  [ROOT_W];
	logic [REM_W+1:0]  diff   [ROOT_W];
	logic [ROOT_W-1:0] fit;

	always_comb begin
		rad_i[0]  = PAD_W'(radicand);
		rem_i[0]  = '0;
		root_i[0] = '0;
		side_i[0] = in_side;
		for (int i = 1; i < ROOT_W; i++) begin
			rad_i[i]  = rad_s[i-1];
			rem_i[i]  = rem_s[i-1];
			root_i[i] = root_s[i-1];
			side_i[i] = side_s[i-1];
		end
		for (int i = 0; i < ROOT_W; i++) begin
			sh[i]    = {rem_i[i], rad_i[i][PAD_W-1 -: 2]};
			trial[i] = (REM_W+2)'({root_i[i], 2'b01});
			fit[i]   = sh[i] >= trial[i];
			diff[i]  = sh[i] - trial[i];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s <= '0;
		else
			v_s <= {v_s[ROOT_W-2:0], in_valid};
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < ROOT_W; i++) begin
			rad_s[i]  <= rad_i[i] << 2;
			rem_s[i]  <= fit[i] ? diff[i][REM_W-1:0] : sh[i][REM_W-1:0];
			root_s[i] <= {root_i[i][ROOT_W-2:0], fit[i]};
			side_s[i] <= side_i[i];
		end
	end

	assign out_valid = v_s[ROOT_W-1];
	assign root      = root_s[ROOT_W-1];
	assign out_side  = side_s[ROOT_W-1];

endmodule

// ===== src/fds_div.sv =====
`timescale 1ns / 1ps
// Pipelined restoring divider, one quotient bit per stage.
// Starts from a partial remainder below the divisor; no package dependency.
module fds_div #(
	parameter int DW     = 38,
	parameter int QW     = 17,
	parameter int SIDE_W = 1
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  logic [DW-1:0]     rem_init,
	input  logic [DW-1:0]     divisor,
	input  logic [QW-1:0]     feed,
	input  logic [SIDE_W-1:0] in_side,
	output logic              out_valid,
	output logic [QW-1:0]     quot,
	output logic [SIDE_W-1:0] out_side
);

	logic [QW-1:0]     v_s;
	logic [DW-1:0]     rem_s  [QW];
	logic [DW-1:0]     den_s  [QW];
	logic [QW-1:0]     feed_s [QW];
	logic [QW-1:0]     q_s    [QW];
	logic [SIDE_W-1:0] side_s [QW];

	logic [DW-1:0]     rem_i  [QW];
	logic [DW-1:0]     den_i  [QW];
	logic [QW-1:0]     feed_i [QW];
	logic [QW-1:0]     q_i    [QW];
	logic [SIDE_W-1:0] side_i [QW];
	logic [DW:0]       sh     [QW];
	logic [DW:0]       diff   [QW];
	logic [QW-1:0]     ge;

	always_comb begin
		rem_i[0]  = rem_init;
		den_i[0]  = divisor;
		feed_i[0] = feed;
		q_i[0]    = '0;
		side_i[0] = in_side;
		for (int i = 1; i < QW; i++) begin
			rem_i[i]  = rem_s[i-1];
			den_i[i]  = den_s[i-1];
			feed_i[i] = feed_s[i-1];
			q_i[i]    = q_s[i-1];
			side_i[i] = side_s[i-1];
		end
		for (int i = 0; i < QW; i++) begin
			sh[i]   = {rem_i[i], feed_i[i][QW-1]};
			ge[i]   = sh[i] >= {1'b0, den_i[i]};
			diff[i] = sh[i] - {1'b0, den_i[i]};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s <= '0;
		else
			v_s <= {v_s[QW-2:0], in_valid};
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < QW; i++) begin
			rem_s[i]  <= ge[i] ? diff[i][DW-1:0] : sh[i][DW-1:0];
			den_s[i]  <= den_i[i];
			feed_s[i] <= feed_i[i] << 1;
			q_s[i]    <= {q_i[i][QW-2:0], ge[i]};
			side_s[i] <= side_i[i];
		end
	end

	assign out_valid = v_s[QW-1];
	assign quot      = q_s[QW-1];
	assign out_side  = side_s[QW-1];

endmodule
